// File: hdl/vula_pkg.sv
// ----------------------------------------------------------------------------
// vula_pkg
// Shared types, constants and decode helpers for the video ULA pixel renderer.
// ----------------------------------------------------------------------------
package vula_pkg;

  localparam int unsigned ScanLimit   = 360;
  localparam int unsigned ColumnLimit = 1023;

  typedef enum logic [2:0] {
    REQ_BYTE   = 3'd0,
    REQ_ENABLE = 3'd1,
    REQ_HSYNC  = 3'd2,
    REQ_VSYNC  = 3'd3,
    REQ_CURSOR = 3'd4
  } vula_req_e;

  typedef enum logic [1:0] {
    CFG_PALETTE = 2'd0,
    CFG_FAST    = 2'd1,
    CFG_MODE    = 2'd2
  } vula_cfg_e;

  // pixel decoding chosen by clock rate and mode code
  typedef enum logic [1:0] {
    KIND_MONO4 = 2'd0,  // 2 colours, 4 px
    KIND_MONO8 = 2'd1,  // 2 colours, 8 px
    KIND_QUAD  = 2'd2,  // 4 colours, 8 px
    KIND_HEX   = 2'd3   // 16 colours, 4 px
  } vula_kind_e;

  // one cell handed from the front to the back
  typedef struct packed {
    logic [7:0] row;
    logic [8:0] column;
    vula_kind_e kind;
    logic [7:0] data;
    logic       cursor;
  } vula_job_t;

  function automatic vula_kind_e vula_kind(input logic fast, input logic [1:0] mode);
    vula_kind_e k;
    k = KIND_MONO4;
    if (fast) begin
      case (mode)
        2'd2:    k = KIND_QUAD;
        2'd1:    k = KIND_HEX;
        default: k = KIND_MONO4;
      endcase
    end else begin
      case (mode)
        2'd1:    k = KIND_QUAD;
        2'd0:    k = KIND_HEX;
        default: k = KIND_MONO8;
      endcase
    end
    return k;
  endfunction

  function automatic logic [3:0] vula_count(input vula_kind_e k);
    logic [3:0] n;
    case (k)
      KIND_MONO8, KIND_QUAD: n = 4'd8;
      default:               n = 4'd4;
    endcase
    return n;
  endfunction

endpackage

// File: hdl/vula_front.sv
// ----------------------------------------------------------------------------
// vula_front
// Beam tracking: column, scanline, top line and cursor flag. Classifies each
// event and pushes a cell job for every screen byte that lands on screen.
// ----------------------------------------------------------------------------
module vula_front #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [2:0]         req_type_i,
  input  logic [7:0]         data_byte_i,
  input  logic               display_enable_i,
  input  logic               fast_clock_i,
  input  logic [1:0]         mode_code_i,
  output logic               push_o,
  output vula_pkg::vula_job_t job_o
);
  import vula_pkg::*;

  logic [9:0] col_q, col_d;
  logic [8:0] scan_q, scan_d;
  logic [8:0] top_q, top_d;
  logic       seen_q, seen_d;
  logic       en_q, en_d;
  logic       cur_q, cur_d;

  vula_kind_e kind;
  logic [3:0]  count;
  logic [10:0] col_sum;
  logic [8:0]  row_diff;
  logic        on_screen;
  logic        fits;

  assign kind      = vula_kind(fast_clock_i, mode_code_i);
  assign count     = vula_count(kind);
  assign col_sum   = {1'b0, col_q} + {7'b0, count};
  assign row_diff  = scan_q - top_q;
  assign on_screen = (scan_q >= top_q) && ({1'b0, row_diff} < 10'(SCREEN_HEIGHT));
  assign fits      = col_sum <= 11'(SCREEN_WIDTH);

  always_comb begin
    col_d  = col_q;
    scan_d = scan_q;
    top_d  = top_q;
    seen_d = seen_q;
    en_d   = en_q;
    cur_d  = cur_q;
    push_o = 1'b0;
    if (accept_i) begin
      case (req_type_i)
        REQ_BYTE: begin
          if (en_q && on_screen) begin
            col_d  = (col_sum > 11'(ColumnLimit)) ? 10'(ColumnLimit) : col_sum[9:0];
            cur_d  = 1'b0;
            push_o = fits;
          end
        end
        REQ_ENABLE: begin
          if (display_enable_i && !en_q) begin
            col_d = '0;
            if (!seen_q) begin
              top_d  = scan_q;
              seen_d = 1'b1;
            end
          end
          en_d = display_enable_i;
        end
        REQ_HSYNC: begin
          col_d  = '0;
          scan_d = (scan_q >= 9'(ScanLimit)) ? 9'(ScanLimit) : scan_q + 9'd1;
        end
        REQ_VSYNC: begin
          col_d  = '0;
          scan_d = '0;
          top_d  = '0;
          seen_d = 1'b0;
        end
        REQ_CURSOR: cur_d = 1'b1;
        default: ;
      endcase
    end
  end

  assign job_o.row    = row_diff[7:0];
  assign job_o.column = col_q[8:0];
  assign job_o.kind   = kind;
  assign job_o.data   = data_byte_i;
  assign job_o.cursor = cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      scan_q <= '0;
      top_q  <= '0;
      seen_q <= 1'b0;
      en_q   <= 1'b0;
      cur_q  <= 1'b0;
    end else begin
      col_q  <= col_d;
      scan_q <= scan_d;
      top_q  <= top_d;
      seen_q <= seen_d;
      en_q   <= en_d;
      cur_q  <= cur_d;
    end
  end

endmodule

// File: hdl/vula_fifo.sv
// ----------------------------------------------------------------------------
// vula_fifo
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module vula_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  vula_pkg::vula_job_t job_i,
  input  logic                pop_i,
  output logic                valid_o,
  output logic                full_o,
  output vula_pkg::vula_job_t job_o
);
  import vula_pkg::*;

  vula_job_t  mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hdl/vula_back.sv
// ----------------------------------------------------------------------------
// vula_back
// Decodes a queued cell through the palette into packed 3-bit pixels,
// applies the cursor inversion and holds the result in the output register.
// ----------------------------------------------------------------------------
module vula_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  vula_pkg::vula_job_t job_i,
  output logic                pop_o,
  input  logic [63:0]         palette_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          row_o,
  output logic [8:0]          column_o,
  output logic [3:0]          pixel_count_o,
  output logic [23:0]         pixels_o,
  output logic                cursor_o
);
  import vula_pkg::*;

  function automatic logic [2:0] phys(input logic [63:0] pal, input logic [3:0] lc);
    return ~pal[{lc, 2'b00} +: 3];
  endfunction

  logic        valid_q;
  logic [7:0]  row_q;
  logic [8:0]  col_q;
  logic [3:0]  cnt_q;
  logic [23:0] pix_q;
  logic        cur_q;

  logic [23:0] pix;
  logic [23:0] pix_fin;
  logic [3:0]  count;
  logic [7:0]  b;
  logic [2:0]  c0, c1;

  assign b     = job_i.data;
  assign count = vula_count(job_i.kind);
  assign c0    = phys(palette_i, {b[7], b[5], b[3], b[1]});
  assign c1    = phys(palette_i, {b[6], b[4], b[2], b[0]});

  always_comb begin
    pix = '0;
    case (job_i.kind)
      KIND_MONO4: begin
        for (int k = 0; k < 4; k++) begin
          pix[3*k +: 3] = phys(palette_i, {3'b000, b[7-2*k]});
        end
      end
      KIND_MONO8: begin
        for (int k = 0; k < 8; k++) begin
          pix[3*k +: 3] = phys(palette_i, {3'b000, b[7-k]});
        end
      end
      KIND_QUAD: begin
        for (int k = 0; k < 4; k++) begin
          pix[6*k +: 3]     = phys(palette_i, {2'b00, b[7-k], b[3-k]});
          pix[6*k + 3 +: 3] = phys(palette_i, {2'b00, b[7-k], b[3-k]});
        end
      end
      default: pix = {12'b0, c1, c1, c0, c0};
    endcase
    pix_fin = pix;
    if (job_i.cursor) begin
      pix_fin = pix ^ ((count == 4'd8) ? 24'hFFFFFF : 24'h000FFF);
    end
  end

  assign pop_o = in_valid_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      row_q <= job_i.row;
      col_q <= job_i.column;
      cnt_q <= count;
      pix_q <= pix_fin;
      cur_q <= job_i.cursor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= in_valid_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign row_o         = row_q;
  assign column_o      = col_q;
  assign pixel_count_o = cnt_q;
  assign pixels_o      = pix_q;
  assign cursor_o      = cur_q;

endmodule

// File: hdl/video_ula_pixel_renderer.sv
// ----------------------------------------------------------------------------
// video_ula_pixel_renderer
// Video ULA pixel serializer: video events in, framebuffer row writes out.
// ----------------------------------------------------------------------------
// Takes one event word per clock (screen byte, display enable level, hsync,
// vsync, cursor mark). A screen byte that lands on screen comes out as one
// row write: the beam-tracking front classifies it and writes the job into
// the queue at the accepting edge, and the back decodes the queue head
// through the palette into the output register once that register is free
// or being read. A two-entry queue sits between the two, so the input keeps
// flowing while a result waits on the output; input ready drops only when
// that queue is full. Events that give no result are absorbed by the front.
// The user must write palette, clock rate and mode through the cfg port
// only while the stream is idle; the block itself does not enforce this.
module video_ula_pixel_renderer #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // data_byte[7:0], display_enable[8], zero
  input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // row[7:0], column[16:8], pixel_count[20:17],
                                      // pixels[44:21], zero
  output logic        m_axis_tuser,   // cursor_applied
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import vula_pkg::*;

  logic [63:0] palette_q;
  logic        fast_q;
  logic [1:0]  mode_q;

  logic      accept;
  logic      push;
  vula_job_t job_in, job_head;
  logic      q_valid, q_full, pop;

  logic [7:0]  row;
  logic [8:0]  column;
  logic [3:0]  count;
  logic [23:0] pixels;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q <= '0;
      fast_q    <= 1'b0;
      mode_q    <= 2'd2;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PALETTE: palette_q <= cfg_data_i;
        CFG_FAST:    fast_q    <= cfg_data_i[0];
        CFG_MODE:    mode_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  vula_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .req_type_i      (s_axis_tuser),
    .data_byte_i     (s_axis_tdata[7:0]),
    .display_enable_i(s_axis_tdata[8]),
    .fast_clock_i    (fast_q),
    .mode_code_i     (mode_q),
    .push_o          (push),
    .job_o           (job_in)
  );

  vula_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .valid_o(q_valid),
    .full_o (q_full),
    .job_o  (job_head)
  );

  vula_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (q_valid),
    .job_i        (job_head),
    .pop_o        (pop),
    .palette_i    (palette_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .row_o        (row),
    .column_o     (column),
    .pixel_count_o(count),
    .pixels_o     (pixels),
    .cursor_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {3'b000, pixels, count, column, row};

endmodule
